@@ rtl/cswe_pkg.sv @@
// Shared types and constants for the cubic spline window evaluator.
// Holds the transfer payload structs, the queued job record and the sequencer states.
// No dependencies.
`default_nettype none

package cswe_pkg;

  localparam int COORD_W   = 32;
  localparam int SEG_W     = 7;
  localparam int T_W       = 16;
  localparam int WGT_W     = 17;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CURVE_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENTS   = 1'd1;

  localparam logic [SEG_W-1:0] SEGMENTS_RESET = 7'd16;

  // Reciprocal of six for an exact divide of values below 2^21.
  localparam logic [19:0] RECIP_SIX   = 20'd699051;
  localparam int          RECIP_SHIFT = 22;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t pt_x;
    coord_t pt_y;
    coord_t pt_z;
    logic   first_point;
  } pt_item_t;

  typedef struct packed {
    coord_t out_x;
    coord_t out_y;
    coord_t out_z;
    logic   last_of_run;
  } cv_item_t;

  typedef struct packed {
    coord_t [3:0] x;
    coord_t [3:0] y;
    coord_t [3:0] z;
  } win_pts_t;

  typedef struct packed {
    win_pts_t         pts;
    logic             mode;
    logic [SEG_W-1:0] segs;
  } job_t;

  typedef enum logic [1:0] {
    GEN_IDLE,
    GEN_DIV,
    GEN_RUN
  } gen_state_t;

endpackage

`default_nettype wire

@@ rtl/cswe_front.sv @@
// Front end: takes point transfers, keeps the last three points of the section
// and queues one job per closed four-point window when at least two segments are set. Depends on cswe_pkg.
`default_nettype none

module cswe_front #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       pt_valid,
  output logic                      pt_stall,
  input  wire cswe_pkg::pt_item_t   pt_data,
  input  wire                       curve_mode,
  input  wire [cswe_pkg::SEG_W-1:0] segments,
  input  wire                       job_full,
  output logic                      job_push,
  output cswe_pkg::job_t            job_data
);
  import cswe_pkg::*;

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_SEGMENTS);

  coord_t     wx [3];
  coord_t     wy [3];
  coord_t     wz [3];
  logic [1:0] held;
  logic [1:0] held_eff;
  logic       accept;
  logic [SEG_W-1:0] seg_eff;

  assign pt_stall = job_full;
  assign accept   = pt_valid && !job_full;
  assign held_eff = pt_data.first_point ? 2'd0 : held;
  assign seg_eff  = (segments > SEG_MAX) ? SEG_MAX : segments;
  assign job_push = accept && (held_eff == 2'd3) && (seg_eff >= SEG_W'(2));

  always_comb begin
    job_data.pts.x = {pt_data.pt_x, wx[2], wx[1], wx[0]};
    job_data.pts.y = {pt_data.pt_y, wy[2], wy[1], wy[0]};
    job_data.pts.z = {pt_data.pt_z, wz[2], wz[1], wz[0]};
    job_data.mode  = curve_mode;
    job_data.segs  = seg_eff;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 2'd0;
    end else if (accept) begin
      if (held_eff == 2'd3) begin
        held <= 2'd3;
      end else begin
        held <= held_eff + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (held_eff == 2'd3) begin
        wx[0] <= wx[1];
        wy[0] <= wy[1];
        wz[0] <= wz[1];
        wx[1] <= wx[2];
        wy[1] <= wy[2];
        wz[1] <= wz[2];
        wx[2] <= pt_data.pt_x;
        wy[2] <= pt_data.pt_y;
        wz[2] <= pt_data.pt_z;
      end else begin
        wx[held_eff] <= pt_data.pt_x;
        wy[held_eff] <= pt_data.pt_y;
        wz[held_eff] <= pt_data.pt_z;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cswe_job_fifo.sv @@
// Two-entry job queue between the front end and the curve back end.
// Depends on cswe_pkg.
`default_nettype none

module cswe_job_fifo (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  wire cswe_pkg::job_t push_data,
  output logic                full,
  input  wire                 pop,
  output cswe_pkg::job_t      pop_data,
  output logic                empty
);
  import cswe_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [PTR_W:0]   cnt;

  assign full     = (cnt == (PTR_W+1)'(DEPTH));
  assign empty    = (cnt == '0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + PTR_W'(1);
      end
      if (pop) begin
        rp <= rp + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt <= cnt + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        cnt <= cnt - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ rtl/cswe_back.sv @@
// Back end: steps t = k/segments for each queued window, forms the cubic basis
// weights and blends the four points in a stalling pipeline. Depends on cswe_pkg.
`default_nettype none

module cswe_back #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 job_valid,
  output logic                job_pop,
  input  wire cswe_pkg::job_t job,
  output logic                cv_valid,
  input  wire                 cv_stall,
  output cswe_pkg::cv_item_t  cv_data
);
  import cswe_pkg::*;

  localparam int K_W = (MAX_SEGMENTS > 2) ? $clog2(MAX_SEGMENTS) : 1;
  localparam logic [4:0] DIV_LAST = 5'd16;

  gen_state_t state;
  gen_state_t state_next;
  logic       load;
  logic       div_step;
  logic       emit;
  logic       adv;

  job_t             job_r;
  logic [16:0]      dv;
  logic [SEG_W:0]   dr;
  logic [16:0]      dq;
  logic [4:0]       cnt;
  logic [T_W-1:0]   t;
  logic [SEG_W-1:0] rem;
  logic [K_W-1:0]   k;

  logic [SEG_W:0]   div_sh;
  logic             div_ge;
  logic [SEG_W:0]   step_sum;
  logic             step_c;
  logic [SEG_W-1:0] rem_next;
  logic [T_W-1:0]   t_next;
  logic [K_W-1:0]   k_next;
  logic             last_step;

  assign adv = !cv_valid || !cv_stall;

  always_comb begin
    state_next = state;
    case (state)
      GEN_IDLE: begin
        if (job_valid) state_next = GEN_DIV;
      end
      GEN_DIV: begin
        if (cnt == DIV_LAST) state_next = GEN_RUN;
      end
      GEN_RUN: begin
        if (adv && last_step) state_next = GEN_IDLE;
      end
      default: state_next = GEN_IDLE;
    endcase
  end

  always_comb begin
    load     = 1'b0;
    div_step = 1'b0;
    emit     = 1'b0;
    case (state)
      GEN_IDLE: load     = job_valid;
      GEN_DIV:  div_step = 1'b1;
      GEN_RUN:  emit     = adv;
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign job_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= GEN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Restoring division of 2^16 by the segment count, one bit per cycle.
  assign div_sh = {dr[SEG_W-1:0], dv[16]};
  assign div_ge = div_sh >= {1'b0, job_r.segs};

  assign step_sum  = {1'b0, rem} + {1'b0, dr[SEG_W-1:0]};
  assign step_c    = step_sum >= {1'b0, job_r.segs};
  assign rem_next  = step_c ? SEG_W'(step_sum - {1'b0, job_r.segs}) : step_sum[SEG_W-1:0];
  assign t_next    = t + dq[T_W-1:0] + T_W'(step_c);
  assign k_next    = k + K_W'(1);
  assign last_step = (SEG_W'(k_next) == (job_r.segs - SEG_W'(1)));

  always_ff @(posedge clk) begin
    if (load) begin
      job_r <= job;
      dv    <= {1'b1, 16'd0};
      dr    <= '0;
      dq    <= '0;
      cnt   <= '0;
      t     <= '0;
      rem   <= job.segs >> 1;
      k     <= '0;
    end
    if (div_step) begin
      dv  <= {dv[15:0], 1'b0};
      dr  <= div_ge ? (div_sh - {1'b0, job_r.segs}) : div_sh;
      dq  <= {dq[15:0], div_ge};
      cnt <= cnt + 5'd1;
    end
    if (emit) begin
      t   <= t_next;
      rem <= rem_next;
      k   <= k_next;
    end
  end

  // Pipeline valid bits, all advancing together.
  logic v1, v2, v3, v4, v5, v6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      v6       <= 1'b0;
      cv_valid <= 1'b0;
    end else if (adv) begin
      v1       <= emit;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      v6       <= v5;
      cv_valid <= v6;
    end
  end

  logic [T_W-1:0] t1, t2s, t3s;
  logic [16:0]    u1, u2s;
  logic [32:0]    tt2, uu2, tu2;
  logic [31:0]    tt3;
  logic [47:0]    t3c;
  logic [48:0]    u3c, tuu3, ttu3;
  logic [18:0]    val4 [4];
  logic [WGT_W-1:0] w5 [4];
  logic signed [49:0] px6 [4];
  logic signed [49:0] py6 [4];
  logic signed [49:0] pz6 [4];
  logic [6:1]     last_p;
  logic [4:1]     mode_p;
  win_pts_t       pts1, pts2, pts3, pts4, pts5;

  logic [51:0] n [4];
  logic [18:0] val_c [4];
  logic [38:0] rprod [4];

  always_comb begin
    n[0] = 52'(u3c);
    n[3] = 52'(t3c);
    n[1] = 52'(3) * 52'(t3c) - ((52'(6) * 52'(tt3)) << 16) + (52'(4) << 48);
    n[2] = (52'(1) << 48) + (52'(3) * 52'(tt3) << 16) + (52'(3) * 52'(t3s) << 32)
         - 52'(3) * 52'(t3c);
    if (mode_p[3]) begin
      n[1] = 52'(3) * 52'(tuu3);
      n[2] = 52'(3) * 52'(ttu3);
    end
    for (int i = 0; i < 4; i++) begin
      if (mode_p[3]) begin
        val_c[i] = 19'((n[i] + (52'(1) << 31)) >> 32);
      end else begin
        val_c[i] = 19'(n[i] >> 32) + 19'd3;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rprod[i] = 39'(val4[i]) * 39'(RECIP_SIX);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: t in Q0.16 and u = 1 - t in Q1.16.
      t1        <= t_next;
      u1        <= 17'h10000 - 17'(t_next);
      last_p[1] <= last_step;
      mode_p[1] <= job_r.mode;
      pts1      <= job_r.pts;
      // Stage 2: squares and cross term.
      tt2       <= 33'(t1) * 33'(t1);
      uu2       <= 33'(u1) * 33'(u1);
      tu2       <= 33'(t1) * 33'(u1);
      t2s       <= t1;
      u2s       <= u1;
      last_p[2] <= last_p[1];
      mode_p[2] <= mode_p[1];
      pts2      <= pts1;
      // Stage 3: cubes.
      t3c       <= 48'(tt2) * 48'(t2s);
      u3c       <= 49'(uu2) * 49'(u2s);
      tuu3      <= 49'(tu2) * 49'(u2s);
      ttu3      <= 49'(tt2) * 49'(u2s);
      tt3       <= tt2[31:0];
      t3s       <= t2s;
      last_p[3] <= last_p[2];
      mode_p[3] <= mode_p[2];
      pts3      <= pts2;
      // Stage 4: weight numerators scaled down to a small value.
      for (int i = 0; i < 4; i++) begin
        val4[i] <= val_c[i];
      end
      last_p[4] <= last_p[3];
      mode_p[4] <= mode_p[3];
      pts4      <= pts3;
      // Stage 5: Q1.16 weights.
      for (int i = 0; i < 4; i++) begin
        w5[i] <= mode_p[4] ? val4[i][WGT_W-1:0] : rprod[i][RECIP_SHIFT +: WGT_W];
      end
      last_p[5] <= last_p[4];
      pts5      <= pts4;
      // Stage 6: point times weight.
      for (int i = 0; i < 4; i++) begin
        px6[i] <= $signed(pts5.x[i]) * $signed({1'b0, w5[i]});
        py6[i] <= $signed(pts5.y[i]) * $signed({1'b0, w5[i]});
        pz6[i] <= $signed(pts5.z[i]) * $signed({1'b0, w5[i]});
      end
      last_p[6] <= last_p[5];
      // Output register: sum, round and saturate.
      cv_data.out_x       <= blend(px6[0], px6[1], px6[2], px6[3]);
      cv_data.out_y       <= blend(py6[0], py6[1], py6[2], py6[3]);
      cv_data.out_z       <= blend(pz6[0], pz6[1], pz6[2], pz6[3]);
      cv_data.last_of_run <= last_p[6];
    end
  end

  function automatic coord_t blend(input logic signed [49:0] a, input logic signed [49:0] b,
                                   input logic signed [49:0] c, input logic signed [49:0] d);
    logic signed [51:0] acc;
    logic signed [35:0] q;
    acc = 52'(a) + 52'(b) + 52'(c) + 52'(d) + 52'sd32768;
    q   = 36'(acc >>> 16);
    if (q > 36'sh07FFFFFFF) begin
      blend = 32'sh7FFFFFFF;
    end else if (q < -36'sh080000000) begin
      blend = 32'sh80000000;
    end else begin
      blend = q[31:0];
    end
  endfunction

endmodule

`default_nettype wire

@@ rtl/cubic_spline_window_evaluator_unit.sv @@
// Top level of the cubic spline window evaluator: configuration registers,
// front end, job queue and curve back end. Depends on cswe_pkg and its submodules.
//
//   Channel  Dir  Handshake            Payload
//   pt       in   pt_valid / pt_stall  cswe_pkg::pt_item_t
//   cv       out  cv_valid / cv_stall  cswe_pkg::cv_item_t
//   cfg      in   cfg_we               cfg_index, cfg_data
//
// The front end stalls point transfers only while the two-entry job queue is full.
// For each window the back end takes the job from the queue, runs a bit-serial
// divide of 2^16 by segments and then issues one curve point per cycle while cv is
// not stalled, segments-1 in all, into its pipeline. A stall on cv freezes the whole
// back-end pipeline. Reset is synchronous.
`default_nettype none

module cubic_spline_window_evaluator_unit #(
  parameter int MAX_SEGMENTS = 64
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           pt_valid,
  output logic                          pt_stall,
  input  wire cswe_pkg::pt_item_t       pt_data,
  output logic                          cv_valid,
  input  wire                           cv_stall,
  output cswe_pkg::cv_item_t            cv_data,
  input  wire                           cfg_we,
  input  wire [cswe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [cswe_pkg::SEG_W-1:0]     cfg_data
);
  import cswe_pkg::*;

  logic             curve_mode;
  logic [SEG_W-1:0] segments;
  logic             job_push;
  job_t             push_data;
  logic             job_full;
  logic             job_pop;
  job_t             pop_data;
  logic             job_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      curve_mode <= 1'b0;
      segments   <= SEGMENTS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CURVE_MODE: curve_mode <= cfg_data[0];
        CFG_SEGMENTS:   segments   <= cfg_data;
        default: begin
          curve_mode <= curve_mode;
        end
      endcase
    end
  end

  cswe_front #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pt_valid   (pt_valid),
    .pt_stall   (pt_stall),
    .pt_data    (pt_data),
    .curve_mode (curve_mode),
    .segments   (segments),
    .job_full   (job_full),
    .job_push   (job_push),
    .job_data   (push_data)
  );

  cswe_job_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (push_data),
    .full      (job_full),
    .pop       (job_pop),
    .pop_data  (pop_data),
    .empty     (job_empty)
  );

  cswe_back #(
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job_pop   (job_pop),
    .job       (pop_data),
    .cv_valid  (cv_valid),
    .cv_stall  (cv_stall),
    .cv_data   (cv_data)
  );

endmodule

`default_nettype wire
